### src/sip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_pkg: shared types for the segment intersection pipeline
// Holds the per-item status flags that travel from the geometry front end
// down the divider chain to the output stage.
// ----------------------------------------------------------------------------
package sip_pkg;

    typedef struct packed {
        logic hit;
        logic want;
        logic colin;
        logic det_zero;
        logic neg_x;
        logic neg_y;
    } sip_flags_t;

endpackage

### src/sip_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_div_cell: one restoring division step for both coordinates
// Compares each partial remainder with the divisor shifted by SHIFT, subtracts
// when it fits and appends one quotient bit, then registers everything.
// ----------------------------------------------------------------------------
module sip_div_cell #(
    parameter int C     = 32,
    parameter int SHIFT = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [3*C+4:0]      in_rem_x,
    input  logic [3*C+4:0]      in_rem_y,
    input  logic [3*C+4:0]      in_dvs,
    input  logic [C+1:0]        in_q_x,
    input  logic [C+1:0]        in_q_y,
    input  sip_pkg::sip_flags_t in_flags,
    input  logic [C-1:0]        in_bx,
    input  logic [C-1:0]        in_by,
    output logic                out_valid,
    output logic [3*C+4:0]      out_rem_x,
    output logic [3*C+4:0]      out_rem_y,
    output logic [3*C+4:0]      out_dvs,
    output logic [C+1:0]        out_q_x,
    output logic [C+1:0]        out_q_y,
    output sip_pkg::sip_flags_t out_flags,
    output logic [C-1:0]        out_bx,
    output logic [C-1:0]        out_by
);

    logic [3*C+4:0]      dk;
    logic                ge_x;
    logic                ge_y;
    logic                valid_reg;
    logic [3*C+4:0]      rem_x_reg;
    logic [3*C+4:0]      rem_y_reg;
    logic [3*C+4:0]      dvs_reg;
    logic [C+1:0]        q_x_reg;
    logic [C+1:0]        q_y_reg;
    sip_pkg::sip_flags_t flags_reg;
    logic [C-1:0]        bx_reg;
    logic [C-1:0]        by_reg;

    assign dk   = in_dvs << SHIFT;
    assign ge_x = in_rem_x >= dk;
    assign ge_y = in_rem_y >= dk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_x_reg <= ge_x ? in_rem_x - dk : in_rem_x;
            rem_y_reg <= ge_y ? in_rem_y - dk : in_rem_y;
            q_x_reg   <= {in_q_x[C:0], ge_x};
            q_y_reg   <= {in_q_y[C:0], ge_y};
            dvs_reg   <= in_dvs;
            flags_reg <= in_flags;
            bx_reg    <= in_bx;
            by_reg    <= in_by;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem_x = rem_x_reg;
    assign out_rem_y = rem_y_reg;
    assign out_dvs   = dvs_reg;
    assign out_q_x   = q_x_reg;
    assign out_q_y   = q_y_reg;
    assign out_flags = flags_reg;
    assign out_bx    = bx_reg;
    assign out_by    = by_reg;

endmodule

### src/sip_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_front: geometry front end of the segment intersection pipeline
// Nine registered stages: box test, exact cross products, line coefficients,
// Cramer numerators and determinant, then the rounded dividend and divisor.
// ----------------------------------------------------------------------------
module sip_front #(
    parameter int C = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [C-1:0]        a_start_x,
    input  logic [C-1:0]        a_start_y,
    input  logic [C-1:0]        a_end_x,
    input  logic [C-1:0]        a_end_y,
    input  logic [C-1:0]        b_start_x,
    input  logic [C-1:0]        b_start_y,
    input  logic [C-1:0]        b_end_x,
    input  logic [C-1:0]        b_end_y,
    input  logic                want_point,
    output logic                out_valid,
    output logic [3*C+4:0]      out_rem_x,
    output logic [3*C+4:0]      out_rem_y,
    output logic [3*C+4:0]      out_dvs,
    output sip_pkg::sip_flags_t out_flags,
    output logic [C-1:0]        out_bx,
    output logic [C-1:0]        out_by
);

    localparam int DW  = C + 1;
    localparam int PW  = 2 * C + 2;
    localparam int OW  = 2 * C + 3;
    localparam int PXW = 2 * C + 3;
    localparam int NW  = 3 * C + 4;
    localparam int W   = 3 * C + 5;

    logic [8:0] vld_reg;

    // Stage 1
    logic signed [C-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [C-1:0] x3_reg, y3_reg, x4_reg, y4_reg;
    logic                want1_reg;
    // Stage 2
    logic signed [DW-1:0] dx31_reg, dy31_reg, dx41_reg, dy41_reg;
    logic signed [DW-1:0] dx13_reg, dy13_reg, dx23_reg, dy23_reg;
    logic signed [DW-1:0] dx21_reg, dy21_reg, dx43_reg, dy43_reg;
    logic signed [DW-1:0] a1_2_reg, a2_2_reg;
    logic signed [C-1:0]  x1_2_reg, y1_2_reg, x3_2_reg, y3_2_reg;
    logic                 box_reg;
    logic                 want2_reg;
    logic signed [C-1:0]  mxa_x, mna_x, mxb_x, mnb_x, mxa_y, mna_y, mxb_y, mnb_y;
    // Stage 3
    logic signed [PW-1:0] m1a_reg, m1b_reg, m2a_reg, m2b_reg;
    logic signed [PW-1:0] m3a_reg, m3b_reg, m4a_reg, m4b_reg;
    logic signed [PW-1:0] c1a_reg, c1b_reg, c2a_reg, c2b_reg, da_reg, db_reg;
    logic signed [DW-1:0] a1_3_reg, b1_3_reg, a2_3_reg, b2_3_reg;
    logic                 box3_reg;
    logic                 want3_reg;
    // Stage 4
    logic signed [OW-1:0] o1, o2, o3, o4;
    logic                 n1, n2, n3, n4, z1, z2, z3, z4, p1, p2, p3, p4;
    logic signed [PW-1:0] c1_reg, c2_reg;
    logic signed [OW-1:0] det4_reg;
    logic signed [DW-1:0] a1_4_reg, b1_4_reg, a2_4_reg, b2_4_reg;
    sip_pkg::sip_flags_t  fl4_reg;
    // Stage 5
    logic signed [DW-1:0]  c1_hi, c2_hi;
    logic signed [DW:0]    c1_lo, c2_lo;
    logic signed [PXW-1:0] pxa_hi_reg, pxa_lo_reg, pxb_hi_reg, pxb_lo_reg;
    logic signed [PXW-1:0] pya_hi_reg, pya_lo_reg, pyb_hi_reg, pyb_lo_reg;
    logic signed [OW-1:0]  det5_reg;
    sip_pkg::sip_flags_t   fl5_reg;
    // Stage 6
    logic signed [NW-1:0] pxa_reg, pxb_reg, pya_reg, pyb_reg;
    logic signed [OW-1:0] det6_reg;
    sip_pkg::sip_flags_t  fl6_reg;
    // Stage 7
    logic signed [NW-1:0] numx_reg, numy_reg;
    logic signed [OW-1:0] det7_reg;
    sip_pkg::sip_flags_t  fl7_reg;
    // Stage 8
    logic [NW-1:0]        anx_reg, any_reg;
    logic [OW-1:0]        ad_reg;
    sip_pkg::sip_flags_t  fl8_reg;
    // Stage 9
    logic [W-1:0]         remx_reg, remy_reg, dvs_reg;
    sip_pkg::sip_flags_t  fl9_reg;
    // B end point carried along
    logic [C-1:0] bx_reg [2:9];
    logic [C-1:0] by_reg [2:9];

    always_comb
    begin
        mxa_x = (x1_reg > x2_reg) ? x1_reg : x2_reg;
        mna_x = (x1_reg > x2_reg) ? x2_reg : x1_reg;
        mxb_x = (x3_reg > x4_reg) ? x3_reg : x4_reg;
        mnb_x = (x3_reg > x4_reg) ? x4_reg : x3_reg;
        mxa_y = (y1_reg > y2_reg) ? y1_reg : y2_reg;
        mna_y = (y1_reg > y2_reg) ? y2_reg : y1_reg;
        mxb_y = (y3_reg > y4_reg) ? y3_reg : y4_reg;
        mnb_y = (y3_reg > y4_reg) ? y4_reg : y3_reg;
    end

    always_comb
    begin
        o1 = OW'(m1a_reg) - OW'(m1b_reg);
        o2 = OW'(m2a_reg) - OW'(m2b_reg);
        o3 = OW'(m3a_reg) - OW'(m3b_reg);
        o4 = OW'(m4a_reg) - OW'(m4b_reg);
        n1 = o1[OW-1];
        n2 = o2[OW-1];
        n3 = o3[OW-1];
        n4 = o4[OW-1];
        z1 = (o1 == '0);
        z2 = (o2 == '0);
        z3 = (o3 == '0);
        z4 = (o4 == '0);
        p1 = !n1 && !z1;
        p2 = !n2 && !z2;
        p3 = !n3 && !z3;
        p4 = !n4 && !z4;
    end

    assign c1_hi = c1_reg[PW-1:DW];
    assign c2_hi = c2_reg[PW-1:DW];
    assign c1_lo = {1'b0, c1_reg[DW-1:0]};
    assign c2_lo = {1'b0, c2_reg[DW-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[7:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= a_start_x;
            y1_reg    <= a_start_y;
            x2_reg    <= a_end_x;
            y2_reg    <= a_end_y;
            x3_reg    <= b_start_x;
            y3_reg    <= b_start_y;
            x4_reg    <= b_end_x;
            y4_reg    <= b_end_y;
            want1_reg <= want_point;

            dx31_reg  <= DW'(x3_reg) - DW'(x1_reg);
            dy31_reg  <= DW'(y3_reg) - DW'(y1_reg);
            dx41_reg  <= DW'(x4_reg) - DW'(x1_reg);
            dy41_reg  <= DW'(y4_reg) - DW'(y1_reg);
            dx13_reg  <= DW'(x1_reg) - DW'(x3_reg);
            dy13_reg  <= DW'(y1_reg) - DW'(y3_reg);
            dx23_reg  <= DW'(x2_reg) - DW'(x3_reg);
            dy23_reg  <= DW'(y2_reg) - DW'(y3_reg);
            dx21_reg  <= DW'(x2_reg) - DW'(x1_reg);
            dy21_reg  <= DW'(y2_reg) - DW'(y1_reg);
            dx43_reg  <= DW'(x4_reg) - DW'(x3_reg);
            dy43_reg  <= DW'(y4_reg) - DW'(y3_reg);
            a1_2_reg  <= DW'(y1_reg) - DW'(y2_reg);
            a2_2_reg  <= DW'(y3_reg) - DW'(y4_reg);
            x1_2_reg  <= x1_reg;
            y1_2_reg  <= y1_reg;
            x3_2_reg  <= x3_reg;
            y3_2_reg  <= y3_reg;
            box_reg   <= (mxa_x >= mnb_x) && (mxb_x >= mna_x) &&
                         (mxa_y >= mnb_y) && (mxb_y >= mna_y);
            want2_reg <= want1_reg;
            bx_reg[2] <= x4_reg;
            by_reg[2] <= y4_reg;

            m1a_reg   <= PW'(dx31_reg) * PW'(dy21_reg);
            m1b_reg   <= PW'(dy31_reg) * PW'(dx21_reg);
            m2a_reg   <= PW'(dx41_reg) * PW'(dy21_reg);
            m2b_reg   <= PW'(dy41_reg) * PW'(dx21_reg);
            m3a_reg   <= PW'(dx13_reg) * PW'(dy43_reg);
            m3b_reg   <= PW'(dy13_reg) * PW'(dx43_reg);
            m4a_reg   <= PW'(dx23_reg) * PW'(dy43_reg);
            m4b_reg   <= PW'(dy23_reg) * PW'(dx43_reg);
            c1a_reg   <= PW'(x1_2_reg) * PW'(a1_2_reg);
            c1b_reg   <= PW'(y1_2_reg) * PW'(dx21_reg);
            c2a_reg   <= PW'(x3_2_reg) * PW'(a2_2_reg);
            c2b_reg   <= PW'(y3_2_reg) * PW'(dx43_reg);
            da_reg    <= PW'(a1_2_reg) * PW'(dx43_reg);
            db_reg    <= PW'(dx21_reg) * PW'(a2_2_reg);
            a1_3_reg  <= a1_2_reg;
            b1_3_reg  <= dx21_reg;
            a2_3_reg  <= a2_2_reg;
            b2_3_reg  <= dx43_reg;
            box3_reg  <= box_reg;
            want3_reg <= want2_reg;
            bx_reg[3] <= bx_reg[2];
            by_reg[3] <= by_reg[2];

            c1_reg           <= c1a_reg + c1b_reg;
            c2_reg           <= c2a_reg + c2b_reg;
            det4_reg         <= OW'(da_reg) - OW'(db_reg);
            a1_4_reg         <= a1_3_reg;
            b1_4_reg         <= b1_3_reg;
            a2_4_reg         <= a2_3_reg;
            b2_4_reg         <= b2_3_reg;
            fl4_reg.hit      <= box3_reg && !((n1 && n2) || (p1 && p2)) &&
                                !((n3 && n4) || (p3 && p4));
            fl4_reg.want     <= want3_reg;
            fl4_reg.colin    <= z1 && z2 && z3 && z4;
            fl4_reg.det_zero <= 1'b0;
            fl4_reg.neg_x    <= 1'b0;
            fl4_reg.neg_y    <= 1'b0;
            bx_reg[4]        <= bx_reg[3];
            by_reg[4]        <= by_reg[3];

            pxa_hi_reg       <= PXW'(c1_hi) * PXW'(b2_4_reg);
            pxa_lo_reg       <= PXW'(c1_lo) * PXW'(b2_4_reg);
            pxb_hi_reg       <= PXW'(c2_hi) * PXW'(b1_4_reg);
            pxb_lo_reg       <= PXW'(c2_lo) * PXW'(b1_4_reg);
            pya_hi_reg       <= PXW'(c2_hi) * PXW'(a1_4_reg);
            pya_lo_reg       <= PXW'(c2_lo) * PXW'(a1_4_reg);
            pyb_hi_reg       <= PXW'(c1_hi) * PXW'(a2_4_reg);
            pyb_lo_reg       <= PXW'(c1_lo) * PXW'(a2_4_reg);
            det5_reg         <= det4_reg;
            fl5_reg          <= '{hit: fl4_reg.hit, want: fl4_reg.want,
                                  colin: fl4_reg.colin, det_zero: (det4_reg == '0),
                                  neg_x: fl4_reg.neg_x, neg_y: fl4_reg.neg_y};
            bx_reg[5]        <= bx_reg[4];
            by_reg[5]        <= by_reg[4];

            pxa_reg   <= (NW'(pxa_hi_reg) <<< DW) + NW'(pxa_lo_reg);
            pxb_reg   <= (NW'(pxb_hi_reg) <<< DW) + NW'(pxb_lo_reg);
            pya_reg   <= (NW'(pya_hi_reg) <<< DW) + NW'(pya_lo_reg);
            pyb_reg   <= (NW'(pyb_hi_reg) <<< DW) + NW'(pyb_lo_reg);
            det6_reg  <= det5_reg;
            fl6_reg   <= fl5_reg;
            bx_reg[6] <= bx_reg[5];
            by_reg[6] <= by_reg[5];

            numx_reg  <= pxa_reg - pxb_reg;
            numy_reg  <= pya_reg - pyb_reg;
            det7_reg  <= det6_reg;
            fl7_reg   <= fl6_reg;
            bx_reg[7] <= bx_reg[6];
            by_reg[7] <= by_reg[6];

            anx_reg       <= numx_reg[NW-1] ? NW'(-numx_reg) : NW'(numx_reg);
            any_reg       <= numy_reg[NW-1] ? NW'(-numy_reg) : NW'(numy_reg);
            ad_reg        <= det7_reg[OW-1] ? OW'(-det7_reg) : OW'(det7_reg);
            fl8_reg       <= '{hit: fl7_reg.hit, want: fl7_reg.want,
                               colin: fl7_reg.colin, det_zero: fl7_reg.det_zero,
                               neg_x: numx_reg[NW-1] ^ det7_reg[OW-1],
                               neg_y: numy_reg[NW-1] ^ det7_reg[OW-1]};
            bx_reg[8]     <= bx_reg[7];
            by_reg[8]     <= by_reg[7];

            remx_reg  <= (W'(anx_reg) << 1) + W'(ad_reg);
            remy_reg  <= (W'(any_reg) << 1) + W'(ad_reg);
            dvs_reg   <= W'(ad_reg) << 1;
            fl9_reg   <= fl8_reg;
            bx_reg[9] <= bx_reg[8];
            by_reg[9] <= by_reg[8];
        end
    end

    assign out_valid = vld_reg[8];
    assign out_rem_x = remx_reg;
    assign out_rem_y = remy_reg;
    assign out_dvs   = dvs_reg;
    assign out_flags = fl9_reg;
    assign out_bx    = bx_reg[9];
    assign out_by    = by_reg[9];

endmodule

### src/segment_intersection_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point: closed segment intersection test with point
// Each item on the input stream carries two segments and a request flag; each
// item on the output stream carries the hit flag and the crossing point.
//
// Input tdata, from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
// b_start_x, b_start_y, b_end_x, b_end_y (COORD_BITS each), want_point.
// Output tdata, from bit 0 up: hit, cross_x, cross_y (COORD_BITS each).
// One item is taken per cycle while s_axis_tready is high, and the block
// returns one item for each, in order. Each item passes through nine
// geometry stages, a chain of COORD_BITS + 2 restoring divider cells that
// each produce one quotient bit, and the output register.
// Reset clears all valid flags; the pipeline is empty and the block accepts
// input in the first cycle after reset.
// When the receiver stalls, one finished item waits in the output register
// and one more in a skid register; the pipeline then holds and s_axis_tready
// falls until the skid register drains.
// ----------------------------------------------------------------------------
module segment_intersection_point #(
    parameter int COORD_BITS = 32,
    localparam int IN_W  = ((8 * COORD_BITS + 8) / 8) * 8,
    localparam int OUT_W = ((2 * COORD_BITS + 8) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
    // b_end_x, b_end_y, want_point
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // hit, cross_x, cross_y
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int C  = COORD_BITS;
    localparam int W  = 3 * C + 5;
    localparam int QW = C + 2;
    localparam int NC = C + 2;

    logic                en;
    logic                vld   [0:NC];
    logic [W-1:0]        rx    [0:NC];
    logic [W-1:0]        ry    [0:NC];
    logic [W-1:0]        dv    [0:NC];
    logic [QW-1:0]       qx    [0:NC];
    logic [QW-1:0]       qy    [0:NC];
    sip_pkg::sip_flags_t fl    [0:NC];
    logic [C-1:0]        bx    [0:NC];
    logic [C-1:0]        by    [0:NC];

    logic                p_valid;
    logic [OUT_W-1:0]    p_data;
    logic [C-1:0]        px;
    logic [C-1:0]        py;
    logic                lim_x;
    logic                lim_y;
    logic [C-1:0]        sat_x;
    logic [C-1:0]        sat_y;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [OUT_W-1:0]    out_data_reg;
    logic [OUT_W-1:0]    out_data_next;
    logic                skid_valid_reg;
    logic                skid_valid_next;
    logic [OUT_W-1:0]    skid_data_reg;
    logic [OUT_W-1:0]    skid_data_next;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    sip_front #(
        .C (C)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (s_axis_tvalid),
        .a_start_x  (s_axis_tdata[C-1:0]),
        .a_start_y  (s_axis_tdata[2*C-1:C]),
        .a_end_x    (s_axis_tdata[3*C-1:2*C]),
        .a_end_y    (s_axis_tdata[4*C-1:3*C]),
        .b_start_x  (s_axis_tdata[5*C-1:4*C]),
        .b_start_y  (s_axis_tdata[6*C-1:5*C]),
        .b_end_x    (s_axis_tdata[7*C-1:6*C]),
        .b_end_y    (s_axis_tdata[8*C-1:7*C]),
        .want_point (s_axis_tdata[8*C]),
        .out_valid  (vld[0]),
        .out_rem_x  (rx[0]),
        .out_rem_y  (ry[0]),
        .out_dvs    (dv[0]),
        .out_flags  (fl[0]),
        .out_bx     (bx[0]),
        .out_by     (by[0])
    );

    assign qx[0] = '0;
    assign qy[0] = '0;

    for (genvar i = 0; i < NC; i++)
    begin : g_cell
        sip_div_cell #(
            .C     (C),
            .SHIFT (C + 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[i]),
            .in_rem_x  (rx[i]),
            .in_rem_y  (ry[i]),
            .in_dvs    (dv[i]),
            .in_q_x    (qx[i]),
            .in_q_y    (qy[i]),
            .in_flags  (fl[i]),
            .in_bx     (bx[i]),
            .in_by     (by[i]),
            .out_valid (vld[i+1]),
            .out_rem_x (rx[i+1]),
            .out_rem_y (ry[i+1]),
            .out_dvs   (dv[i+1]),
            .out_q_x   (qx[i+1]),
            .out_q_y   (qy[i+1]),
            .out_flags (fl[i+1]),
            .out_bx    (bx[i+1]),
            .out_by    (by[i+1])
        );
    end

    always_comb
    begin
        lim_x = (qx[NC][QW-1:C-1] != '0);
        lim_y = (qy[NC][QW-1:C-1] != '0);
        if (fl[NC].neg_x)
        begin
            sat_x = lim_x ? {1'b1, {(C-1){1'b0}}} : C'(-qx[NC][C-1:0]);
        end
        else
        begin
            sat_x = lim_x ? {1'b0, {(C-1){1'b1}}} : qx[NC][C-1:0];
        end
        if (fl[NC].neg_y)
        begin
            sat_y = lim_y ? {1'b1, {(C-1){1'b0}}} : C'(-qy[NC][C-1:0]);
        end
        else
        begin
            sat_y = lim_y ? {1'b0, {(C-1){1'b1}}} : qy[NC][C-1:0];
        end

        if (!fl[NC].hit || !fl[NC].want)
        begin
            px = '0;
            py = '0;
        end
        else if (fl[NC].colin)
        begin
            px = bx[NC];
            py = by[NC];
        end
        else if (fl[NC].det_zero)
        begin
            px = '0;
            py = '0;
        end
        else
        begin
            px = sat_x;
            py = sat_y;
        end

        p_data           = '0;
        p_data[0]        = fl[NC].hit;
        p_data[C:1]      = px;
        p_data[2*C:C+1]  = py;
    end

    assign p_valid = en && vld[NC];

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = p_valid;
                out_data_next  = p_data;
            end
        end
        else if (p_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = p_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output is empty");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_axis_tready))
        else $error("skid register filled without an output stall");

    a_miss_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg[0]) |-> (out_data_reg[2*C:1] == '0))
        else $error("miss reported with a nonzero crossing point");

endmodule
